// ----- rtl/rtcl_pkg.sv -----
`default_nettype none

package rtcl_pkg;

    // Input actions.
    localparam logic [1:0] ACT_LOAD_STRIPE = 2'd0;
    localparam logic [1:0] ACT_LOAD_CHUNK  = 2'd1;
    localparam logic [1:0] ACT_LOOKUP      = 2'd2;
    localparam logic [1:0] ACT_NONE        = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_FOUND        = 2'd0;
    localparam logic [1:0] ST_NO_INDEX     = 2'd1;
    localparam logic [1:0] ST_ROW_PAST     = 2'd2;
    localparam logic [1:0] ST_OUTSIDE      = 2'd3;

    // Configuration register indexes and port geometry.
    localparam logic [1:0] REG_HAS_CHUNK_INDEX = 2'd0;
    localparam logic [1:0] REG_FIRST_STRIPE    = 2'd1;
    localparam logic [1:0] REG_STRIPE_COUNT    = 2'd2;
    localparam int         APB_AW              = 4;

    // Width of a stored cumulative chunk count.
    localparam int STRIPE_END_W = 13;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] entry_index;
        logic [31:0] load_value;
        logic [31:0] load_byte_offset;
        logic [31:0] stripe;
        logic [31:0] row;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] chunk_byte_offset;
        logic [31:0] chunk_first_row;
    } out_word_t;

    typedef struct packed {
        logic        has_chunk_index;
        logic [31:0] first_stripe;
        logic [8:0]  stripe_count;
    } cfg_t;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
    } alu_res_t;

endpackage

`default_nettype wire

// ----- rtl/rtcl_ram.sv -----
`default_nettype none

module rtcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/rtcl_alu.sv -----
`default_nettype none

module rtcl_alu
    import rtcl_pkg::*;
(
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output alu_res_t         res
);

    // One 33-bit subtractor; the top bit is the borrow, set when a < b.
    logic [32:0] wide_diff;

    assign wide_diff  = {1'b0, a} - {1'b0, b};
    assign res.diff   = wide_diff[31:0];
    assign res.borrow = wide_diff[32];

endmodule

`default_nettype wire

// ----- rtl/rtcl_cfg.sv -----
`default_nettype none

module rtcl_cfg
    import rtcl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_AW-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_index)
                REG_HAS_CHUNK_INDEX: cfg_next.has_chunk_index = pwdata[0];
                REG_FIRST_STRIPE:    cfg_next.first_stripe    = pwdata;
                REG_STRIPE_COUNT:    cfg_next.stripe_count    = pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_HAS_CHUNK_INDEX: prdata = {31'd0, cfg_reg.has_chunk_index};
            REG_FIRST_STRIPE:    prdata = cfg_reg.first_stripe;
            REG_STRIPE_COUNT:    prdata = {23'd0, cfg_reg.stripe_count};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/row_to_chunk_locator.sv -----
`default_nettype none

// Row-to-chunk locator. Load words fill a per-stripe table of cumulative chunk
// counts (action 0) and a per-chunk table of cumulative row ends and byte
// offsets (action 1); each load is written in the cycle it is accepted. A lookup
// word (action 2) names a global stripe and a row and returns one result word
// holding a status, the byte offset of the chunk that holds the row and the row
// at which that chunk starts. Outcomes that need no table read (stripe outside
// the group, no chunk index) are settled in the check state. A full lookup runs
// the check, two stripe-table reads, a setup, the binary-search probes, a final
// check and the offset read; there are at most ceil(log2(chunks in stripe + 1))
// probes. The probe rate is one per cycle, set by the registered read port of
// the row-end memory; the two stripe-table reads before the search and the
// offset read after it each have a state of their own. The block takes one
// lookup at a time and is not ready while it works, but a finished result may
// wait in the output register while the next words are accepted. The tables
// hold no reset value: an entry must be written before a lookup reads it.
// Configuration is written over the APB port at byte addresses 0, 4 and 8.
module row_to_chunk_locator
    import rtcl_pkg::*;
#(
    parameter int MAX_STRIPES = 256,
    parameter int MAX_CHUNKS  = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input word channel.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_word_t          s_data,
    // Result word channel.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    // Address width of each table, count width that can hold MAX_CHUNKS
    // itself, and a compare width that covers both the count and a stored
    // chunk count.
    localparam int SA = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
    localparam int CA = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int EW = (CW > STRIPE_END_W) ? CW : STRIPE_END_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RD0   = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_SETUP = 4'd5;
    localparam logic [3:0] S_SRCH  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_RES   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    cfg_t cfg;

    rtcl_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Control state.
    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Working registers of one lookup.
    logic [31:0]             stripe_reg, stripe_next;
    logic [31:0]             row_reg, row_next;
    logic [SA-1:0]           local_reg, local_next;
    logic [STRIPE_END_W-1:0] start_raw_reg, start_raw_next;
    logic [CW-1:0]           start_reg, start_next;
    logic [CW-1:0]           end_reg, end_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic                    first_zero_reg, first_zero_next;
    out_word_t               res_reg, res_next;
    out_word_t               out_reg, out_next;

    // Memory ports.
    logic                    stripe_we;
    logic [SA-1:0]           stripe_waddr, stripe_raddr;
    logic [STRIPE_END_W-1:0] stripe_rdata;
    logic                    chunk_we;
    logic [CA-1:0]           chunk_waddr, row_raddr, off_raddr;
    logic [31:0]             row_rdata, off_rdata;

    // Shared subtractor.
    logic [31:0] alu_a, alu_b;
    alu_res_t    alu;

    // Helpers.
    logic          in_acc;
    logic [31:0]   idx32;
    logic [31:0]   local32;
    logic          outside;
    logic [EW-1:0] end_ext, max_ext, end_cl, start_ext;
    logic [CW-1:0] half;
    logic          row_le;
    logic [CW-1:0] srch_lo, srch_cnt;
    logic          out_load;

    assign s_ready = (state_reg == S_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Load words write the tables straight from the input word.
    assign idx32        = {20'd0, s_data.entry_index};
    assign stripe_we    = in_acc && (s_data.action == ACT_LOAD_STRIPE)
                          && (idx32 < 32'(MAX_STRIPES));
    assign chunk_we     = in_acc && (s_data.action == ACT_LOAD_CHUNK)
                          && (idx32 < 32'(MAX_CHUNKS));
    assign stripe_waddr = idx32[SA-1:0];
    assign chunk_waddr  = idx32[CA-1:0];

    rtcl_ram #(.WIDTH(STRIPE_END_W), .DEPTH(MAX_STRIPES)) u_stripe_end (
        .aclk  (aclk),
        .we    (stripe_we),
        .waddr (stripe_waddr),
        .wdata (s_data.load_value[STRIPE_END_W-1:0]),
        .raddr (stripe_raddr),
        .rdata (stripe_rdata)
    );

    rtcl_ram #(.WIDTH(32), .DEPTH(MAX_CHUNKS)) u_row_end (
        .aclk  (aclk),
        .we    (chunk_we),
        .waddr (chunk_waddr),
        .wdata (s_data.load_value),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    rtcl_ram #(.WIDTH(32), .DEPTH(MAX_CHUNKS)) u_offset (
        .aclk  (aclk),
        .we    (chunk_we),
        .waddr (chunk_waddr),
        .wdata (s_data.load_byte_offset),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    // The one subtractor serves the local stripe, the range length and the
    // row compare of every probe; the state picks its operands.
    always_comb begin
        unique case (state_reg)
            S_CHECK: begin
                alu_a = stripe_reg;
                alu_b = cfg.first_stripe;
            end
            S_RD2: begin
                alu_a = 32'(end_cl);
                alu_b = {19'd0, start_raw_reg};
            end
            S_SRCH: begin
                alu_a = row_reg;
                alu_b = row_rdata;
            end
            default: begin
                alu_a = 32'd0;
                alu_b = 32'd0;
            end
        endcase
    end

    rtcl_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu)
    );

    // A stripe is outside the group if it lies below the first stripe or its
    // local index reaches the stripe count or the table depth.
    assign local32 = alu.diff;
    assign outside = alu.borrow || (local32 >= {23'd0, cfg.stripe_count})
                     || (local32 >= 32'(MAX_STRIPES));

    // The stripe's end count is clamped to the table depth; its start is not,
    // since a start beyond the end already means an empty range.
    assign end_ext   = EW'(stripe_rdata);
    assign max_ext   = EW'(MAX_CHUNKS);
    assign end_cl    = (end_ext > max_ext) ? max_ext : end_ext;
    assign start_ext = EW'(start_raw_reg);

    // Lower-bound step: a probe whose row end is not above the row moves the
    // window past itself, any other probe keeps the left half.
    assign half     = cnt_reg >> 1;
    assign row_le   = !alu.borrow;
    assign srch_lo  = row_le ? (mid_reg + CW'(1)) : lo_reg;
    assign srch_cnt = row_le ? (cnt_reg - half - CW'(1)) : half;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        stripe_next     = stripe_reg;
        row_next        = row_reg;
        local_next      = local_reg;
        start_raw_next  = start_raw_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        lo_next         = lo_reg;
        cnt_next        = cnt_reg;
        mid_next        = mid_reg;
        first_zero_next = first_zero_reg;
        res_next        = res_reg;
        stripe_raddr    = local_reg;
        row_raddr       = mid_reg[CA-1:0];
        off_raddr       = lo_reg[CA-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (s_data.action)
                        ACT_LOOKUP: begin
                            stripe_next = s_data.stripe;
                            row_next    = s_data.row;
                            state_next  = S_CHECK;
                        end
                        ACT_LOAD_STRIPE, ACT_LOAD_CHUNK, ACT_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_CHECK: begin
                local_next = local32[SA-1:0];
                res_next   = '0;
                if (outside) begin
                    res_next.status = ST_OUTSIDE;
                    state_next      = S_DONE;
                end else if (!cfg.has_chunk_index) begin
                    res_next.status = ST_NO_INDEX;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_RD0;
                end
            end
            S_RD0: begin
                // Previous stripe's end is this stripe's start.
                stripe_raddr = local_reg - SA'(1);
                state_next   = S_RD1;
            end
            S_RD1: begin
                stripe_raddr   = local_reg;
                start_raw_next = (local_reg == '0) ? '0 : stripe_rdata;
                state_next     = S_RD2;
            end
            S_RD2: begin
                if (alu.borrow || (alu.diff == 32'd0)) begin
                    res_next.status = ST_ROW_PAST;
                    state_next      = S_DONE;
                end else begin
                    start_next = start_ext[CW-1:0];
                    lo_next    = start_ext[CW-1:0];
                    end_next   = end_cl[CW-1:0];
                    cnt_next   = alu.diff[CW-1:0];
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                mid_next   = lo_reg + half;
                row_raddr  = mid_next[CA-1:0];
                state_next = S_SRCH;
            end
            S_SRCH: begin
                lo_next  = srch_lo;
                cnt_next = srch_cnt;
                if (srch_cnt != '0) begin
                    mid_next  = srch_lo + (srch_cnt >> 1);
                    row_raddr = mid_next[CA-1:0];
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (lo_reg >= end_reg) begin
                    res_next.status = ST_ROW_PAST;
                    state_next      = S_DONE;
                end else begin
                    // The chunk's first row is the previous chunk's row end.
                    off_raddr       = lo_reg[CA-1:0];
                    row_raddr       = CA'(lo_reg - CW'(1));
                    first_zero_next = (lo_reg == start_reg);
                    state_next      = S_RES;
                end
            end
            S_RES: begin
                res_next.status            = ST_FOUND;
                res_next.chunk_byte_offset = off_rdata;
                res_next.chunk_first_row   = first_zero_reg ? 32'd0 : row_rdata;
                state_next                 = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register holds a result until it is taken, so loads keep
    // flowing in while a result waits.
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stripe_reg     <= stripe_next;
        row_reg        <= row_next;
        local_reg      <= local_next;
        start_raw_reg  <= start_raw_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        lo_reg         <= lo_next;
        cnt_reg        <= cnt_next;
        mid_reg        <= mid_next;
        first_zero_reg <= first_zero_next;
        res_reg        <= res_next;
        out_reg        <= out_next;
    end

    // The search window is never empty while a probe is in flight.
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH) |-> (cnt_reg != '0))
        else $error("probe issued over an empty search window");

    // The lower bound never passes the end of the stripe's chunk range.
    a_lo_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SRCH) || (state_reg == S_FIN)) |-> (lo_reg <= end_reg))
        else $error("search lower bound beyond end of chunk range");

    // A result that is not a found chunk carries location 0,0.
    a_empty_location: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_FOUND)) |->
            ((m_data.chunk_byte_offset == 32'd0) && (m_data.chunk_first_row == 32'd0)))
        else $error("non-found result with nonzero location");

    // Tables are written only while no lookup is in progress.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (stripe_we || chunk_we) |=> (state_reg == S_IDLE))
        else $error("table load started a lookup");

endmodule

`default_nettype wire

// ----- dv/chunk_location_checker.sv -----
`default_nettype none

module chunk_location_checker
    import rtcl_pkg::*;
#(
    parameter int MAX_STRIPES = 256,
    parameter int MAX_CHUNKS  = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire in_word_t          s_data,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire out_word_t         m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output int                     mismatches,
    output int                     pending,
    output logic [3:0][15:0]       status_tally
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                    group_cfg;
    logic [STRIPE_END_W-1:0] stripe_end_tbl [MAX_STRIPES];
    logic [31:0]             row_end_tbl    [MAX_CHUNKS];
    logic [31:0]             offset_tbl     [MAX_CHUNKS];
    out_word_t               predicted_locations [$];

    initial begin
        mismatches   = 0;
        pending      = 0;
        status_tally = '0;
        group_cfg    = '0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    // Lower-bound search over the stripe's chunk range, probing exactly as the block does.
    function automatic out_word_t locate_row(input logic [31:0] stripe, input logic [31:0] row);
        out_word_t   r;
        logic [31:0] lc;
        logic [31:0] lo_c;
        logic [31:0] hi_c;
        logic [31:0] lo;
        logic [31:0] span;
        logic [31:0] half;
        logic [31:0] mid;
        r = '0;
        r.status = ST_OUTSIDE;
        if (stripe < group_cfg.first_stripe) return r;
        lc = stripe - group_cfg.first_stripe;
        if (lc >= 32'(group_cfg.stripe_count) || lc >= 32'(MAX_STRIPES)) return r;
        r.status = ST_NO_INDEX;
        if (!group_cfg.has_chunk_index) return r;
        lo_c = (lc == 0) ? 32'd0 : 32'(stripe_end_tbl[lc - 1]);
        hi_c = 32'(stripe_end_tbl[lc]);
        if (hi_c > 32'(MAX_CHUNKS)) hi_c = 32'(MAX_CHUNKS);
        r.status = ST_ROW_PAST;
        if (lo_c >= hi_c) return r;
        lo   = lo_c;
        span = hi_c - lo_c;
        while (span != 0) begin
            half = span / 2;
            mid  = lo + half;
            if (row_end_tbl[mid] <= row) begin
                lo   = mid + 1;
                span = span - half - 1;
            end else begin
                span = half;
            end
        end
        if (lo >= hi_c) return r;
        r.status            = ST_FOUND;
        r.chunk_byte_offset = offset_tbl[lo];
        r.chunk_first_row   = (lo == lo_c) ? 32'd0 : row_end_tbl[lo - 1];
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            group_cfg = '0;
            predicted_locations.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_HAS_CHUNK_INDEX: group_cfg.has_chunk_index = pwdata[0];
                    REG_FIRST_STRIPE:    group_cfg.first_stripe    = pwdata;
                    REG_STRIPE_COUNT:    group_cfg.stripe_count    = pwdata[8:0];
                    default: ;
                endcase
            end
            // A result never leaves in the cycle its lookup is taken, so results go first.
            if (m_valid && m_ready) begin
                if (!$isunknown(m_data.status))
                    status_tally[m_data.status] = status_tally[m_data.status] + 1;
                if (predicted_locations.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no lookup waiting", m_data));
                end else begin
                    want = predicted_locations.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch($sformatf("status %h, expected %h",
                                                  m_data.status, want.status));
                    if (m_data.chunk_byte_offset !== want.chunk_byte_offset)
                        report_mismatch($sformatf("chunk_byte_offset %h, expected %h",
                                                  m_data.chunk_byte_offset,
                                                  want.chunk_byte_offset));
                    if (m_data.chunk_first_row !== want.chunk_first_row)
                        report_mismatch($sformatf("chunk_first_row %h, expected %h",
                                                  m_data.chunk_first_row,
                                                  want.chunk_first_row));
                end
            end
            if (s_valid && s_ready) begin
                case (s_data.action)
                    ACT_LOAD_STRIPE: begin
                        if (32'(s_data.entry_index) < 32'(MAX_STRIPES))
                            stripe_end_tbl[s_data.entry_index] =
                                s_data.load_value[STRIPE_END_W-1:0];
                    end
                    ACT_LOAD_CHUNK: begin
                        if (32'(s_data.entry_index) < 32'(MAX_CHUNKS)) begin
                            row_end_tbl[s_data.entry_index] = s_data.load_value;
                            offset_tbl[s_data.entry_index]  = s_data.load_byte_offset;
                        end
                    end
                    ACT_LOOKUP: predicted_locations.push_back(locate_row(s_data.stripe, s_data.row));
                    default: ;
                endcase
            end
        end
        pending = predicted_locations.size();
    end

endmodule

`default_nettype wire

// ----- dv/tb_row_to_chunk_locator.sv -----
`default_nettype none

// The top builds the stimulus for the locator and gives the verdict. A checker module beside the
// block watches both word channels and the configuration port, predicts every lookup result and
// counts mismatches; this module only drives words, configures the group and handles flow control.
module tb_row_to_chunk_locator;
    import rtcl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int STRIPE_SLOTS  = 256;
    localparam int CHUNK_SLOTS   = 4096;
    // Covers any word still in flight once every predicted result has come back.
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_word_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_word_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    int               mismatches;
    int               pending;
    logic [3:0][15:0] status_tally;

    // Flow-control knobs shared between the stimulus and the receiver.
    logic calm       = 1'b0;
    int   hold_asks  = 0;
    int   holds_done = 0;
    int   hold_left  = 0;
    int   quiet      = 0;

    // The group as last configured, and a shadow of what the tables hold. The shadow is only
    // used to keep random lookups away from table entries that were never written.
    logic        index_on;
    logic [31:0] group_first;
    logic [8:0]  group_size;
    logic [STRIPE_END_W-1:0] stripe_end_m [STRIPE_SLOTS];
    logic [31:0]             row_end_m    [CHUNK_SLOTS];
    bit                      stripe_set   [STRIPE_SLOTS];
    bit                      chunk_set    [CHUNK_SLOTS];
    int chunks_built     = 0;
    int words_sent       = 0;
    int lookups_sent     = 0;
    int settings_applied = 0;

    always #HALF_PERIOD aclk = ~aclk;

    row_to_chunk_locator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    chunk_location_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .status_tally (status_tally)
    );

    // Unless calm, the receiver drops ready 18 times in a hundred. When the stimulus asks for a
    // hold, it keeps ready low for a long stretch so the block backs up and stalls its input.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asks != holds_done) begin
            holds_done <= hold_asks;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 18);
        end
    end

    // Watchdog: any accepted word or register write counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one word and returns in the time step at which it is accepted. Valid stays high
    // into the next word unless a random idle cycle is taken first.
    task automatic send_word(input in_word_t w);
        if (!calm) begin
            while ($urandom_range(99) < 18) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent = words_sent + 1;
        case (w.action)
            ACT_LOAD_STRIPE: begin
                if (32'(w.entry_index) < STRIPE_SLOTS) begin
                    stripe_end_m[w.entry_index] = w.load_value[STRIPE_END_W-1:0];
                    stripe_set[w.entry_index]   = 1'b1;
                end
            end
            ACT_LOAD_CHUNK: begin
                row_end_m[w.entry_index] = w.load_value;
                chunk_set[w.entry_index] = 1'b1;
            end
            ACT_LOOKUP: lookups_sent = lookups_sent + 1;
            default: ;
        endcase
    endtask

    // A word with all fields but the action random; fields the action does not use stay random.
    function automatic in_word_t noise_word(input logic [1:0] act);
        in_word_t w;
        w.action           = act;
        w.entry_index      = 12'($urandom);
        w.load_value       = $urandom;
        w.load_byte_offset = $urandom;
        w.stripe           = $urandom;
        w.row              = $urandom;
        return w;
    endfunction

    task automatic stripe_load(input logic [11:0] idx, input logic [31:0] val);
        in_word_t w;
        w = noise_word(ACT_LOAD_STRIPE);
        w.entry_index = idx;
        w.load_value  = val;
        send_word(w);
    endtask

    task automatic chunk_load(input logic [11:0] idx, input logic [31:0] row_end,
                              input logic [31:0] offset);
        in_word_t w;
        w = noise_word(ACT_LOAD_CHUNK);
        w.entry_index      = idx;
        w.load_value       = row_end;
        w.load_byte_offset = offset;
        send_word(w);
    endtask

    task automatic lookup(input logic [31:0] stripe, input logic [31:0] row);
        in_word_t w;
        w = noise_word(ACT_LOOKUP);
        w.stripe = stripe;
        w.row    = row;
        send_word(w);
    endtask

    // Register write: setup, then access. The trailing idle cycle keeps psel from
    // being lowered and raised in the same time step when writes come back to back.
    task automatic apb_write(input logic [1:0] reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every predicted result has come back, then lets any trailing load settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic has_index, input logic [31:0] first,
                             input logic [8:0] count);
        drain();
        apb_write(REG_HAS_CHUNK_INDEX, {31'd0, has_index});
        apb_write(REG_FIRST_STRIPE, first);
        apb_write(REG_STRIPE_COUNT, {23'd0, count});
        index_on         = has_index;
        group_first      = first;
        group_size       = count;
        settings_applied = settings_applied + 1;
    endtask

    // True when a lookup of this stripe and row only reads table entries already written.
    // It follows the same probe sequence the block uses.
    function automatic bit lookup_is_safe(input logic [31:0] stripe, input logic [31:0] row);
        logic [31:0] lc;
        logic [31:0] lo_c;
        logic [31:0] hi_c;
        logic [31:0] lo;
        logic [31:0] span;
        logic [31:0] half;
        logic [31:0] mid;
        if (stripe < group_first) return 1'b1;
        lc = stripe - group_first;
        if (lc >= 32'(group_size) || lc >= STRIPE_SLOTS || !index_on) return 1'b1;
        if (!stripe_set[lc] || (lc != 0 && !stripe_set[lc - 1])) return 1'b0;
        lo_c = (lc == 0) ? 32'd0 : 32'(stripe_end_m[lc - 1]);
        hi_c = 32'(stripe_end_m[lc]);
        if (hi_c > CHUNK_SLOTS) hi_c = CHUNK_SLOTS;
        if (lo_c >= hi_c) return 1'b1;
        lo   = lo_c;
        span = hi_c - lo_c;
        while (span != 0) begin
            half = span / 2;
            mid  = lo + half;
            if (!chunk_set[mid]) return 1'b0;
            if (row_end_m[mid] <= row) begin
                lo   = mid + 1;
                span = span - half - 1;
            end else begin
                span = half;
            end
        end
        if (lo >= hi_c) return 1'b1;
        return chunk_set[lo] && (lo == lo_c || chunk_set[lo - 1]);
    endfunction

    // Fills the group with well-formed stripes: each stripe gets a run of chunks with
    // non-decreasing row ends that restart at zero, and its cumulative chunk count.
    // Some counts carry random bits above the stored width.
    task automatic build_layout(input int max_n);
        int          next_chunk;
        int          n;
        logic [31:0] row_acc;
        logic [31:0] count_word;
        next_chunk = 0;
        for (int s = 0; s < int'(group_size); s++) begin
            if ($urandom_range(3) != 0) begin
                n = $urandom_range(0, (max_n < 3) ? max_n : 3);
            end else begin
                n = $urandom_range(0, max_n);
            end
            if (next_chunk + n > CHUNK_SLOTS) n = CHUNK_SLOTS - next_chunk;
            row_acc = 32'd0;
            for (int c = 0; c < n; c++) begin
                // Occasional zero steps make empty chunks; occasional big steps spread the rows.
                if ($urandom_range(9) != 0) begin
                    row_acc = row_acc + (($urandom_range(3) == 0) ?
                              $urandom_range(1, 32'h00FF_FFFF) : $urandom_range(1, 40));
                end
                chunk_load(12'(next_chunk + c), row_acc, $urandom);
            end
            next_chunk = next_chunk + n;
            count_word = 32'(next_chunk);
            if ($urandom_range(3) == 0) count_word = count_word | ($urandom & 32'hFFFF_E000);
            stripe_load(12'(s), count_word);
        end
        chunks_built = next_chunk;
    endtask

    // Mostly lookups aimed at the group and at chunk boundaries, the rest noise: unsorted
    // row ends, rewritten chunk counts, loads past the stripe table and unused actions.
    task automatic random_traffic(input int ops);
        int          pick;
        int          k;
        int          tries;
        bit          ok;
        logic [31:0] st;
        logic [31:0] rw;
        logic [31:0] lc;
        logic [31:0] lo_c;
        logic [31:0] hi_c;
        logic [31:0] c;
        in_word_t    w;
        repeat (ops) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                ok    = 1'b0;
                tries = 0;
                while (!ok && tries < 8) begin
                    k = $urandom_range(9);
                    if (k < 7) begin
                        st = group_first + $urandom_range(0, group_size);
                    end else if (k == 7) begin
                        st = group_first - $urandom_range(1, 3);
                    end else begin
                        st = $urandom;
                    end
                    lc = st - group_first;
                    rw = $urandom;
                    k  = $urandom_range(9);
                    if (k == 0) begin
                        rw = 32'd0;
                    end else if (k == 1) begin
                        rw = 32'hFFFF_FFFF;
                    end else if (k < 8 && lc < 32'(group_size) && stripe_set[lc] &&
                                 (lc == 0 || stripe_set[lc - 1])) begin
                        // Land just below, on, or just above a chunk's row end.
                        lo_c = (lc == 0) ? 32'd0 : 32'(stripe_end_m[lc - 1]);
                        hi_c = 32'(stripe_end_m[lc]);
                        if (hi_c > CHUNK_SLOTS) hi_c = CHUNK_SLOTS;
                        if (lo_c < hi_c) begin
                            c = $urandom_range(lo_c, hi_c - 1);
                            if (chunk_set[c]) rw = row_end_m[c] + $urandom_range(0, 2) - 1;
                        end
                    end
                    ok    = lookup_is_safe(st, rw);
                    tries = tries + 1;
                end
                // Fall back to a stripe just outside the group, which reads no table.
                if (!ok) st = (group_first != 0) ? group_first - 1 : 32'hFFFF_FFFF;
                lookup(st, rw);
            end else if (pick < 84) begin
                if ($urandom_range(2) == 0 || chunks_built == 0) begin
                    c = $urandom_range(0, CHUNK_SLOTS - 1);
                end else begin
                    c = $urandom_range(0, chunks_built - 1);
                end
                chunk_load(12'(c), $urandom, $urandom);
            end else if (pick < 89) begin
                stripe_load(12'($urandom_range(0, STRIPE_SLOTS - 1)),
                            ($urandom & 32'hFFFF_E000) | $urandom_range(0, chunks_built));
            end else if (pick < 94) begin
                w = noise_word(ACT_LOAD_STRIPE);
                w.entry_index = 12'($urandom_range(STRIPE_SLOTS, CHUNK_SLOTS - 1));
                send_word(w);
            end else begin
                send_word(noise_word(ACT_NONE));
            end
        end
    endtask

    initial begin
        index_on    = 1'b0;
        group_first = 32'd0;
        group_size  = 9'd0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed group: five stripes starting at global stripe 100. Stripe 1 is empty,
        // stripe 2 holds an empty first chunk and a chunk ending at the largest row, the
        // count of stripe 4 has high bits set and is clamped to the table size.
        configure(1'b1, 32'd100, 9'd5);
        stripe_load(12'd0, 32'd2);
        stripe_load(12'd1, 32'd2);
        stripe_load(12'd2, 32'hFFFF_E005);
        stripe_load(12'd3, 32'd4094);
        stripe_load(12'd4, 32'hFFFF_FFFF);
        stripe_load(12'd4095, 32'd0);
        chunk_load(12'd0, 32'd10, 32'hFFFF_FFFF);
        chunk_load(12'd1, 32'd20, 32'h0000_1000);
        chunk_load(12'd2, 32'd0, 32'd0);
        chunk_load(12'd3, 32'd5, 32'h0000_2000);
        chunk_load(12'd4, 32'hFFFF_FFFF, 32'h8000_0000);
        chunk_load(12'd4094, 32'd7, 32'h1234_5678);
        chunk_load(12'd4095, 32'd9, 32'h8765_4321);
        send_word(noise_word(ACT_NONE));
        lookup(32'd100, 32'd0);
        lookup(32'd100, 32'd10);
        lookup(32'd100, 32'd20);
        lookup(32'd101, 32'd3);
        lookup(32'd102, 32'd0);
        lookup(32'd102, 32'hFFFF_FFFE);
        lookup(32'd102, 32'hFFFF_FFFF);
        lookup(32'd104, 32'd7);
        lookup(32'd99, 32'd0);
        lookup(32'd105, 32'd0);
        lookup(32'hFFFF_FFFF, 32'd0);

        // Without a chunk index every stripe in the group answers with no location, while the
        // group bounds are still checked first.
        configure(1'b0, 32'd100, 9'd5);
        lookup(32'd100, 32'd0);
        lookup(32'd99, 32'd0);

        // Random phases. The first one opens with a long result hold-off while words keep
        // coming, so the block fills up and stalls its input.
        configure(1'b1, 32'd0, 9'd6);
        hold_asks <= hold_asks + 1;
        build_layout(5);
        random_traffic(90);

        configure(1'b1, 32'hFFFF_FFFF, 9'd1);
        build_layout(40);
        random_traffic(70);

        // A full group of stripes with no idling on either side.
        calm <= 1'b1;
        configure(1'b1, $urandom, 9'd256);
        build_layout(1);
        random_traffic(80);
        calm <= 1'b0;

        configure(1'b0, $urandom_range(0, 1000), 9'($urandom_range(1, 16)));
        build_layout(3);
        random_traffic(50);

        configure(1'b1, 32'hFFFF_FF00, 9'd0);
        random_traffic(30);

        configure(1'b1, $urandom_range(0, 1000), 9'($urandom_range(2, 12)));
        build_layout(60);
        random_traffic(120);

        drain();
        $display("Run covered %0d input words, %0d of them lookups, over %0d group settings.",
                 words_sent, lookups_sent, settings_applied);
        $display("Outcomes: %0d found, %0d no chunk index, %0d row past stripe, %0d outside group.",
                 status_tally[ST_FOUND], status_tally[ST_NO_INDEX],
                 status_tally[ST_ROW_PAST], status_tally[ST_OUTSIDE]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- row_to_chunk_locator.f -----
rtl/rtcl_pkg.sv
rtl/rtcl_ram.sv
rtl/rtcl_alu.sv
rtl/rtcl_cfg.sv
rtl/row_to_chunk_locator.sv
dv/chunk_location_checker.sv
dv/tb_row_to_chunk_locator.sv
